// File: design/kmt_pkg.sv
// Shared types, codes and character tables for the multi-tap keypad entry block.
`default_nettype none
package kmt_pkg;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_INSERT  = 2'd1,
        ACT_REPLACE = 2'd2,
        ACT_DELETE  = 2'd3
    } edit_act_t;

    localparam logic [1:0] MODE_DIGIT = 2'd0;
    localparam logic [1:0] MODE_ENGLISH = 2'd1;
    localparam logic [1:0] MODE_SYMBOL = 2'd2;

    localparam logic [3:0] KEY_SPACE = 4'd10;
    localparam logic [3:0] KEY_DELETE = 4'd11;

    localparam logic CFG_INPUT_MODE = 1'b0;
    localparam logic CFG_UPPER_CASE = 1'b1;

    localparam logic [6:0] CH_NUL = 7'h00;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DIGIT0 = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_UPPER_Z = 7'h5A;
    localparam logic [6:0] CASE_OFFSET = 7'h20;

    typedef struct packed {
        edit_act_t  act;
        logic [6:0] char_code;
        logic       pend_we;
        logic [6:0] pend_next;
    } step_result_t;

    // Three table characters per key, first character in the top byte.
    // A two-character row has a zero in the bottom byte.
    function automatic logic [23:0] tap_row(input logic sym, input logic [3:0] key);
        logic [23:0] row;
        row = 24'h0;
        if (!sym) begin
            unique case (key)
                4'd0: row = "@?!";
                4'd1: row = "ABC";
                4'd2: row = "DEF";
                4'd3: row = "GHI";
                4'd4: row = "JKL";
                4'd5: row = "MNO";
                4'd6: row = "PQR";
                4'd7: row = "STU";
                4'd8: row = "VWX";
                4'd9: row = "YZ.";
                default: row = 24'h0;
            endcase
        end else begin
            unique case (key)
                4'd0: row = "~.^";
                4'd1: row = "!@#";
                4'd2: row = "$%&";
                4'd3: row = "*()";
                4'd4: row = "+{}";
                4'd5: row = "[]=";
                4'd6: row = "<>|";
                4'd7: row = {"-_", 8'h00};
                4'd8: row = {":;", 8'h00};
                4'd9: row = "\"'/";
                default: row = 24'h0;
            endcase
        end
        return row;
    endfunction

endpackage
`default_nettype wire

// File: design/kmt_step.sv
// Combinational decode of one key press into an edit action and the next pending character.
`default_nettype none
module kmt_step (
    input  wire logic [3:0]          key_code,
    input  wire logic                buffer_full,
    input  wire logic [1:0]          input_mode,
    input  wire logic                upper_case,
    input  wire logic [6:0]          pend_char,
    output kmt_pkg::step_result_t    result
);
    import kmt_pkg::*;

    logic [23:0] row;
    logic [6:0]  c0;
    logic [6:0]  c1;
    logic [6:0]  c2;
    logic        len3;
    logic [6:0]  tap_next;
    edit_act_t   tap_act;
    logic [6:0]  tap_out;

    assign row  = tap_row(input_mode == MODE_SYMBOL, key_code);
    assign c0   = row[22:16];
    assign c1   = row[14:8];
    assign c2   = row[6:0];
    assign len3 = (c2 != CH_NUL);

    // Multi-tap run: the same key steps through its row, any other key starts over.
    always_comb begin
        tap_next = c0;
        tap_act  = ACT_REPLACE;
        if (pend_char == CH_NUL) begin
            tap_act = ACT_INSERT;
        end else if (pend_char == c0) begin
            tap_next = c1;
        end else if (pend_char == c1) begin
            tap_next = len3 ? c2 : c0;
        end else if (len3 && pend_char == c2) begin
            tap_next = c0;
        end else begin
            tap_act = ACT_INSERT;
        end
        if (!upper_case && tap_next >= CH_UPPER_A && tap_next <= CH_UPPER_Z) begin
            tap_out = tap_next + CASE_OFFSET;
        end else begin
            tap_out = tap_next;
        end
    end

    always_comb begin
        result.act       = ACT_NONE;
        result.char_code = CH_NUL;
        result.pend_we   = 1'b0;
        result.pend_next = CH_NUL;
        if (!buffer_full && input_mode <= MODE_SYMBOL && key_code <= KEY_DELETE) begin
            result.pend_we = 1'b1;
            if (key_code == KEY_DELETE) begin
                result.act = ACT_DELETE;
            end else if (input_mode == MODE_DIGIT) begin
                result.act       = ACT_INSERT;
                result.char_code = (key_code == KEY_SPACE) ? CH_SPACE
                                                           : CH_DIGIT0 + {3'b000, key_code};
            end else if (key_code == KEY_SPACE) begin
                // A space only commits a pending character; with none pending it is inserted.
                if (pend_char == CH_NUL) begin
                    result.act       = ACT_INSERT;
                    result.char_code = CH_SPACE;
                end
            end else begin
                result.act       = tap_act;
                result.char_code = tap_out;
                result.pend_next = tap_next;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/keypad_multitap_char_entry.sv
// Top level of the multi-tap keypad entry block: request registers, state and result register.
`default_nettype none
// Multi-tap keypad character entry. Each key request passes an input register, a short
// table lookup and compare, and a result register: one request is taken every clock cycle
// while the output is not stalled, and the result register loads its result on the same
// edge at which it moves out of the input register. The pending character is updated on
// the same edge that loads the result, so back-to-back requests of a multi-tap run do not
// stall. The user must write configuration through the cfg port only while the block is
// idle; the block itself does not enforce it.
module keypad_multitap_char_entry (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [3:0] key_code, [4] buffer_full, [7:5] zero
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
    output      logic [1:0] m_tuser,   // [1:0] edit_action
    input  wire logic       cfg_valid,
    output      logic       cfg_ready,
    input  wire logic       cfg_index,
    input  wire logic [1:0] cfg_data
);
    import kmt_pkg::*;

    logic         in_vld_reg;
    logic         in_vld_next;
    logic [3:0]   in_key_reg;
    logic         in_full_reg;
    logic         out_vld_reg;
    logic         out_vld_next;
    edit_act_t    out_act_reg;
    logic [6:0]   out_char_reg;
    logic [6:0]   pend_reg;
    logic [6:0]   pend_next;
    logic [1:0]   mode_reg;
    logic         upper_reg;
    logic         advance;
    logic         s_take;
    step_result_t step_res;

    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    kmt_step u_step (
        .key_code    (in_key_reg),
        .buffer_full (in_full_reg),
        .input_mode  (mode_reg),
        .upper_case  (upper_reg),
        .pend_char   (pend_reg),
        .result      (step_res)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tready) begin
            in_vld_next = s_tvalid;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
        pend_next = pend_reg;
        if (advance && step_res.pend_we) begin
            pend_next = step_res.pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            pend_reg    <= CH_NUL;
            mode_reg    <= MODE_ENGLISH;
            upper_reg   <= 1'b1;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            pend_reg    <= pend_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_INPUT_MODE) begin
                    mode_reg <= cfg_data;
                end else if (cfg_index == CFG_UPPER_CASE) begin
                    upper_reg <= cfg_data[0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_key_reg  <= s_tdata[3:0];
            in_full_reg <= s_tdata[4];
        end
        if (advance) begin
            out_act_reg  <= step_res.act;
            out_char_reg <= step_res.char_code;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tuser  = out_act_reg;

`ifndef SYNTH
    // A processed delete always leaves no pending character.
    a_delete_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_key_reg == KEY_DELETE && !in_full_reg && mode_reg <= MODE_SYMBOL
        |=> pend_reg == CH_NUL)
        else $error("pending character survived a delete");

    // While a replace result waits, a pending character is still held.
    a_replace_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_act_reg == ACT_REPLACE |-> pend_reg != CH_NUL)
        else $error("replace result without a pending character");

    // Results without a character carry zero.
    a_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && (out_act_reg == ACT_NONE || out_act_reg == ACT_DELETE)
        |-> out_char_reg == CH_NUL)
        else $error("character on a none or delete result");

    // Input back-pressure only when both stages are full and the output is stalled.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_vld_reg && out_vld_reg && !m_tready)
        else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire

// File: test/keypad_multitap_char_entry_test.sv
// Self-checking testbench for the multi-tap keypad character entry block.
module keypad_multitap_char_entry_test;
    import kmt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 16;
    localparam int PHASE_PRESSES = 108;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT = 300;
    localparam int CALM_FROM = 900;
    localparam int CALM_TO = 1200;
    localparam int DRAIN_CYCLES = 6;

    // Three characters per digit key, key 0 first. A blank marks a missing third character.
    localparam logic [8*30-1:0] LETTER_KEYS = "@?!ABCDEFGHIJKLMNOPQRSTUVWXYZ.";
    localparam logic [8*30-1:0] SYMBOL_KEYS = "~.^!@#$%&*()+{}[]=<>|-_ :; \"'/";

    typedef enum logic { ROW_KEY, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic       reg_index;
        logic [1:0] reg_value;
        logic [3:0] key;
        logic       full;
        logic       typed;
        edit_act_t  act;
        logic [6:0] char_code;
    } script_row_t;

    typedef struct packed {
        edit_act_t  act;
        logic [6:0] char_code;
    } edit_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [1:0] cfg_data;

    logic [1:0] mode_now;
    logic       upper_now;
    logic [6:0] pending_now;
    edit_t      edits_due [$];
    int         errors;
    int         presses_sent;
    int         edits_seen;
    int         hold_left;
    bit         hold_done;
    int         cycles;

    script_row_t script [0:27] = '{
        '{ROW_KEY, 1'b0, 2'd0, 4'd1,  1'b0, 1'b1, ACT_INSERT,  CH_UPPER_A},
        '{ROW_KEY, 1'b0, 2'd0, 4'd1,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd1,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd1,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd2,  1'b1, 1'b1, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd10, 1'b0, 1'b1, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd10, 1'b0, 1'b1, ACT_INSERT,  CH_SPACE},
        '{ROW_KEY, 1'b0, 2'd0, 4'd15, 1'b0, 1'b1, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd9,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd11, 1'b0, 1'b1, ACT_DELETE,  CH_NUL},
        '{ROW_CFG, CFG_UPPER_CASE, 2'd0, 4'd0, 1'b0, 1'b0, ACT_NONE, CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd9,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd9,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd9,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_CFG, CFG_INPUT_MODE, MODE_SYMBOL, 4'd0, 1'b0, 1'b0, ACT_NONE, CH_NUL},
        // The period left pending by the letter key continues its run on the symbol key that owns it.
        '{ROW_KEY, 1'b0, 2'd0, 4'd0,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd7,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd7,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd7,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_CFG, CFG_INPUT_MODE, 2'd3, 4'd0, 1'b0, 1'b0, ACT_NONE, CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd5,  1'b0, 1'b1, ACT_NONE,    CH_NUL},
        '{ROW_CFG, CFG_INPUT_MODE, MODE_DIGIT, 4'd0, 1'b0, 1'b0, ACT_NONE, CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd0,  1'b0, 1'b1, ACT_INSERT,  CH_DIGIT0},
        '{ROW_KEY, 1'b0, 2'd0, 4'd9,  1'b0, 1'b0, ACT_NONE,    CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd10, 1'b0, 1'b1, ACT_INSERT,  CH_SPACE},
        '{ROW_KEY, 1'b0, 2'd0, 4'd11, 1'b0, 1'b1, ACT_DELETE,  CH_NUL},
        '{ROW_KEY, 1'b0, 2'd0, 4'd12, 1'b1, 1'b1, ACT_NONE,    CH_NUL},
        '{ROW_CFG, CFG_UPPER_CASE, 2'd3, 4'd0, 1'b0, 1'b0, ACT_NONE, CH_NUL}
    };

    keypad_multitap_char_entry dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [6:0] tap_char(input logic sym, input logic [3:0] key,
                                            input int slot);
        int pos;
        pos = int'(key) * 3 + slot;
        if (sym) begin
            return SYMBOL_KEYS[8*(29-pos) +: 7];
        end
        return LETTER_KEYS[8*(29-pos) +: 7];
    endfunction

    // Works out the edit caused by one key press and advances the pending character.
    function automatic edit_t next_edit(input logic [3:0] key, input logic full);
        edit_t      e;
        logic       sym;
        logic [6:0] c0, c1, c2, nxt;
        bit         three;
        e.act = ACT_NONE;
        e.char_code = CH_NUL;
        if (!full && mode_now <= MODE_SYMBOL && key <= KEY_DELETE) begin
            if (key == KEY_DELETE) begin
                e.act = ACT_DELETE;
                pending_now = CH_NUL;
            end else if (mode_now == MODE_DIGIT) begin
                e.act = ACT_INSERT;
                e.char_code = (key == KEY_SPACE) ? CH_SPACE : CH_DIGIT0 + {3'b000, key};
                pending_now = CH_NUL;
            end else if (key == KEY_SPACE) begin
                if (pending_now == CH_NUL) begin
                    e.act = ACT_INSERT;
                    e.char_code = CH_SPACE;
                end
                pending_now = CH_NUL;
            end else begin
                sym = (mode_now == MODE_SYMBOL);
                c0 = tap_char(sym, key, 0);
                c1 = tap_char(sym, key, 1);
                c2 = tap_char(sym, key, 2);
                three = !(sym && (key == 4'd7 || key == 4'd8));
                e.act = ACT_REPLACE;
                if (pending_now == CH_NUL) begin
                    nxt = c0;
                    e.act = ACT_INSERT;
                end else if (pending_now == c0) begin
                    nxt = c1;
                end else if (pending_now == c1) begin
                    nxt = three ? c2 : c0;
                end else if (three && pending_now == c2) begin
                    nxt = c0;
                end else begin
                    nxt = c0;
                    e.act = ACT_INSERT;
                end
                pending_now = nxt;
                if (!upper_now && nxt >= CH_UPPER_A && nxt <= CH_UPPER_Z) begin
                    e.char_code = nxt + CASE_OFFSET;
                end else begin
                    e.char_code = nxt;
                end
            end
        end
        return e;
    endfunction

    task automatic press(input logic [3:0] key, input logic full, input bit typed = 0,
                         input edit_t typed_edit = '0);
        edit_t e;
        bit    calm;
        calm = presses_sent >= CALM_FROM && presses_sent < CALM_TO;
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, full, key};
        do @(posedge aclk); while (!s_tready);
        e = next_edit(key, full);
        edits_due.push_back(typed ? typed_edit : e);
        presses_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (edits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_INPUT_MODE) begin
            mode_now = value;
        end else begin
            upper_now = value[0];
        end
    endtask

    // Result side: checks each accepted edit and throttles m_tready.
    always @(posedge aclk) begin
        edit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            edits_seen++;
            if (edits_due.size() == 0) begin
                $display("%0t: unexpected edit, action %0d char %0h", $time, m_tuser,
                         m_tdata[6:0]);
                errors++;
            end else begin
                want = edits_due.pop_front();
                if (m_tuser != want.act) begin
                    $display("%0t: edit_action expected %0d actual %0d", $time, want.act,
                             m_tuser);
                    errors++;
                end
                if (m_tdata[6:0] != want.char_code) begin
                    $display("%0t: char_code expected %0h actual %0h", $time,
                             want.char_code, m_tdata[6:0]);
                    errors++;
                end
            end
            if (edits_seen == HOLD_AT && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (edits_seen >= CALM_FROM && edits_seen < CALM_TO) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 26);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int         r;
        int         reps;
        int         sent;
        logic [3:0] key;
        edit_t      typed_edit;
        errors = 0;
        presses_sent = 0;
        edits_seen = 0;
        hold_left = 0;
        hold_done = 0;
        cycles = 0;
        mode_now = MODE_ENGLISH;
        upper_now = 1'b1;
        pending_now = CH_NUL;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_INPUT_MODE;
        cfg_data <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                settle();
                write_reg(script[i].reg_index, script[i].reg_value);
            end else begin
                typed_edit.act = script[i].act;
                typed_edit.char_code = script[i].char_code;
                press(script[i].key, script[i].full, script[i].typed, typed_edit);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            if (phase == 0) begin
                write_reg(CFG_INPUT_MODE, MODE_DIGIT);
                write_reg(CFG_UPPER_CASE, 2'd0);
            end else if (phase == 1) begin
                write_reg(CFG_INPUT_MODE, MODE_SYMBOL);
                write_reg(CFG_UPPER_CASE, 2'd1);
            end else begin
                r = $urandom_range(9);
                write_reg(CFG_INPUT_MODE, r < 4 ? MODE_ENGLISH : r < 8 ? MODE_SYMBOL :
                          r == 8 ? MODE_DIGIT : 2'd3);
                write_reg(CFG_UPPER_CASE, 2'($urandom_range(3)));
            end
            sent = 0;
            while (sent < PHASE_PRESSES) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    press(4'($urandom_range(15)), 1'($urandom_range(1)));
                    sent++;
                end else if (r < 15) begin
                    press(KEY_DELETE, 1'b0);
                    sent++;
                end else if (r < 20) begin
                    press(KEY_SPACE, 1'b0);
                    sent++;
                end else begin
                    // A multi-tap run on one key, sometimes closed with a space.
                    key = 4'($urandom_range(9));
                    reps = $urandom_range(1, 4);
                    for (int k = 0; k < reps; k++) begin
                        press(key, $urandom_range(19) == 0);
                    end
                    sent += reps;
                    if ($urandom_range(2) == 0) begin
                        press(KEY_SPACE, 1'b0);
                        sent++;
                    end
                end
            end
        end

        settle();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: keypad_multitap_char_entry.f
design/kmt_pkg.sv
design/kmt_step.sv
design/keypad_multitap_char_entry.sv
test/keypad_multitap_char_entry_test.sv
